// ===== rtl/swe_pkg.sv =====
// Shared types and constants for the sliding window extremum block.
// No dependencies; imported by the sequencer and the top level.
`timescale 1ns / 1ps

package swe_pkg;

  // Fixed widths of the configuration registers and of the write port.
  localparam int WINDOW_SIZE_W = 7;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 7;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIND_MINIMUM = 1'b1;

  // Configuration as seen by the sequencer.
  typedef struct packed {
    logic [WINDOW_SIZE_W-1:0] window_size;
    logic                     find_minimum;
  } cfg_t;

endpackage

// ===== rtl/sliding_window_extremum.sv =====
// Top level of the sliding window extremum block: configuration registers,
// output register and the deque sequencer. Depends on swe_pkg and swe_seq.
`timescale 1ns / 1ps

// This block reports the running maximum, or the minimum when find_minimum is
// set, of the last window_size signed samples. It keeps a monotonic deque of
// sample values and their positions in a dual-read, single-write memory of
// WINDOW_MAX entries. A window_size of zero behaves as one, and a value above
// WINDOW_MAX behaves as WINDOW_MAX. A request with start_of_sequence set
// empties the deque and restarts the sample count before that sample is taken.
// No result is produced until window_size samples have been taken since the
// start of the sequence; after that, every request yields one result. Each
// request occupies the sequencer through the head check, the pop steps for
// the tail entries that the new sample removes, the append and the output
// step; memory reads are registered, and a sample can be removed only once.
// A request that produces no result skips the output step. A finished
// result sits in the output register, so the next request is taken while
// the downstream side still stalls. The memory needs no clearing after
// reset; only data of occupied entries is ever used.
// Configuration writes are to be made only while no request is in progress.

module sliding_window_extremum
  import swe_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_start_of_sequence,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_extremum
);

  cfg_t                          cfg_r, cfg_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_extremum_r, out_extremum_nxt;
  logic                          res_valid;
  logic signed [SAMPLE_BITS-1:0] res_value;
  logic                          res_free;

  // Configuration registers. Unused upper data bits of the one-bit mode
  // register are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WINDOW_SIZE: begin
          cfg_nxt.window_size = cfg_data[WINDOW_SIZE_W-1:0];
        end
        CFG_FIND_MINIMUM: begin
          cfg_nxt.find_minimum = cfg_data[0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  // The output register can take a new result when it is empty or when its
  // current result leaves in this cycle.
  assign res_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_extremum_nxt = out_extremum_r;
    if (res_valid && res_free) begin
      out_valid_nxt    = 1'b1;
      out_extremum_nxt = res_value;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_size  <= WINDOW_SIZE_W'(1);
      cfg_r.find_minimum <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_extremum_r <= out_extremum_nxt;
  end

  swe_seq #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sample            (in_sample),
    .in_start_of_sequence (in_start_of_sequence),
    .res_valid            (res_valid),
    .res_value            (res_value),
    .res_free             (res_free)
  );

  assign out_valid    = out_valid_r;
  assign out_extremum = out_extremum_r;

endmodule

// ===== rtl/swe_deque_mem.sv =====
// Deque storage: one write port and two read ports with registered read data.
// Standalone; instantiated by swe_seq.
`timescale 1ns / 1ps

module swe_deque_mem #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 23
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [DATA_W-1:0]                          wr_data,
  input  logic                                       rd_en_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  output logic [DATA_W-1:0]                          rd_data_a,
  input  logic                                       rd_en_b,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  output logic [DATA_W-1:0]                          rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds between reads so a consumer may wait on it.
  always_ff @(posedge clk) begin
    if (rd_en_a) begin
      rd_data_a <= mem[rd_addr_a];
    end
    if (rd_en_b) begin
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== rtl/swe_seq.sv =====
// Deque sequencer: head expiry, tail pops, append and head read-out per sample.
// Depends on swe_pkg and swe_deque_mem.
`timescale 1ns / 1ps

module swe_seq
  import swe_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_start_of_sequence,
  output logic                          res_valid,
  output logic signed [SAMPLE_BITS-1:0] res_value,
  input  logic                          res_free
);

  localparam int ADDR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int POS_MOD = 2 * WINDOW_MAX;
  localparam int POS_W   = $clog2(POS_MOD);
  localparam int AGE_W   = POS_W + 1;
  localparam int CMP_W   = (CNT_W > WINDOW_SIZE_W) ? CNT_W : WINDOW_SIZE_W;
  localparam int ENTRY_W = SAMPLE_BITS + POS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HEAD   = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [ADDR_W-1:0]             head_r, head_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [CNT_W-1:0]              seen_r, seen_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [POS_W-1:0]              spos_r, spos_nxt;
  logic [CNT_W-1:0]              win_r, win_nxt;
  logic                          min_r, min_nxt;
  logic                          emit_r, emit_nxt;
  logic                          first_r, first_nxt;

  logic                          mem_wr_en;
  logic [ADDR_W-1:0]             mem_wr_addr;
  logic [ENTRY_W-1:0]            mem_wr_data;
  logic                          mem_rd_en_a, mem_rd_en_b;
  logic [ADDR_W-1:0]             mem_rd_addr_a, mem_rd_addr_b;
  logic [ENTRY_W-1:0]            mem_rd_data_a, mem_rd_data_b;

  logic [CMP_W-1:0]              win_wide;
  logic [CNT_W-1:0]              win_eff;
  logic [ADDR_W-1:0]             h_start, h1, h2;
  logic [CNT_W-1:0]              c_start, c1, c2, s_start;
  logic [POS_W-1:0]              p_start;
  logic [POS_W-1:0]              head_pos;
  logic [AGE_W-1:0]              age;
  logic                          drop, full;
  logic signed [SAMPLE_BITS-1:0] tail_val;
  logic                          dominated;

  // Circular slot arithmetic: base + offset modulo the deque depth.
  function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  offs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offs);
    if (sum >= SUM_W'(WINDOW_MAX)) begin
      sum = sum - SUM_W'(WINDOW_MAX);
    end
    return sum[ADDR_W-1:0];
  endfunction

  swe_deque_mem #(
    .DEPTH  (WINDOW_MAX),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_en_a   (mem_rd_en_a),
    .rd_addr_a (mem_rd_addr_a),
    .rd_data_a (mem_rd_data_a),
    .rd_en_b   (mem_rd_en_b),
    .rd_addr_b (mem_rd_addr_b),
    .rd_data_b (mem_rd_data_b)
  );

  // Window length clamped into 1..WINDOW_MAX.
  always_comb begin
    win_wide = CMP_W'(cfg.window_size);
    if (win_wide == '0) begin
      win_wide = CMP_W'(1);
    end else if (win_wide > CMP_W'(WINDOW_MAX)) begin
      win_wide = CMP_W'(WINDOW_MAX);
    end
    win_eff = win_wide[CNT_W-1:0];
  end

  // Age of the head entry relative to the sample in flight.
  always_comb begin
    head_pos = mem_rd_data_a[POS_W-1:0];
    age      = AGE_W'(spos_r) - AGE_W'(head_pos);
    if (spos_r < head_pos) begin
      age = age + AGE_W'(POS_MOD);
    end
  end

  // Tail dominance: the new sample replaces tail entries that can never win.
  always_comb begin
    tail_val  = $signed(mem_rd_data_b[ENTRY_W-1 -: SAMPLE_BITS]);
    dominated = min_r ? (tail_val >= sample_r) : (tail_val <= sample_r);
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    seen_nxt   = seen_r;
    sample_nxt = sample_r;
    spos_nxt   = spos_r;
    win_nxt    = win_r;
    min_nxt    = min_r;
    emit_nxt   = emit_r;
    first_nxt  = first_r;

    mem_wr_en     = 1'b0;
    mem_wr_addr   = head_r;
    mem_wr_data   = {sample_r, spos_r};
    mem_rd_en_a   = 1'b0;
    mem_rd_addr_a = head_r;
    mem_rd_en_b   = 1'b0;
    mem_rd_addr_b = head_r;

    in_stall  = (state_r != S_IDLE);
    res_valid = 1'b0;
    res_value = first_r ? sample_r : $signed(mem_rd_data_a[ENTRY_W-1 -: SAMPLE_BITS]);

    h_start = in_start_of_sequence ? '0 : head_r;
    c_start = in_start_of_sequence ? '0 : count_r;
    p_start = in_start_of_sequence ? '0 : pos_r;
    s_start = in_start_of_sequence ? '0 : seen_r;

    drop = (count_r != '0) && (age >= AGE_W'(win_r));
    h1   = drop ? slot_add(head_r, CNT_W'(1)) : head_r;
    c1   = drop ? (count_r - CNT_W'(1)) : count_r;

    full = (count_r >= CNT_W'(WINDOW_MAX));
    h2   = full ? slot_add(head_r, CNT_W'(1)) : head_r;
    c2   = full ? (count_r - CNT_W'(1)) : count_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample;
          min_nxt    = cfg.find_minimum;
          win_nxt    = win_eff;
          head_nxt   = h_start;
          count_nxt  = c_start;
          spos_nxt   = p_start;
          pos_nxt    = (p_start == POS_W'(POS_MOD - 1)) ? '0 : (p_start + POS_W'(1));
          seen_nxt   = (s_start < win_eff) ? (s_start + CNT_W'(1)) : win_eff;
          emit_nxt   = (((s_start < win_eff) ? (s_start + CNT_W'(1)) : win_eff) == win_eff);
          // Head and tail are fetched together; the tail slot stays the same
          // whether or not the head expires.
          mem_rd_en_a   = 1'b1;
          mem_rd_addr_a = h_start;
          mem_rd_en_b   = 1'b1;
          mem_rd_addr_b = slot_add(h_start, c_start - CNT_W'(1));
          state_nxt     = S_HEAD;
        end
      end
      S_HEAD: begin
        head_nxt = h1;
        if ((c1 != '0) && dominated) begin
          count_nxt     = c1 - CNT_W'(1);
          mem_rd_en_b   = 1'b1;
          mem_rd_addr_b = slot_add(h1, c1 - CNT_W'(2));
          state_nxt     = S_POP;
        end else begin
          count_nxt = c1;
          state_nxt = S_APPEND;
        end
      end
      S_POP: begin
        if ((count_r != '0) && dominated) begin
          count_nxt     = count_r - CNT_W'(1);
          mem_rd_en_b   = 1'b1;
          mem_rd_addr_b = slot_add(head_r, count_r - CNT_W'(2));
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        head_nxt      = h2;
        count_nxt     = c2 + CNT_W'(1);
        mem_wr_en     = 1'b1;
        mem_wr_addr   = slot_add(h2, c2);
        // The written slot differs from the head unless the deque was empty,
        // and then the head value is the sample itself.
        mem_rd_en_a   = 1'b1;
        mem_rd_addr_a = h2;
        first_nxt     = (c2 == '0);
        state_nxt     = emit_r ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      pos_r   <= '0;
      seen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    spos_r   <= spos_nxt;
    win_r    <= win_nxt;
    min_r    <= min_nxt;
    emit_r   <= emit_nxt;
    first_r  <= first_nxt;
  end

endmodule

// ===== test/swe_checker.sv =====
// Scoreboard for the sliding window extremum block: watches the register
// writes and both request channels, predicts each result and compares it.
// Depends on swe_pkg for the register indexes and the configuration layout.
`timescale 1ns / 1ps

module swe_checker
  import swe_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_start_of_sequence,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_extremum,
  output int                            mismatch_count,
  output int                            pending_results
);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam int POS_MOD   = 2 * WINDOW_MAX;
  // The block holds at most a couple of results at once, so a small ring of
  // expected values is plenty.
  localparam int DUE_DEPTH = 8;

  cfg_t    regs;
  sample_t kept_values [WINDOW_MAX];
  int      kept_pos    [WINDOW_MAX];
  int      head;
  int      depth;
  int      next_pos;
  int      seen;
  int      errors = 0;
  sample_t due_values [DUE_DEPTH];
  int      due_rd;
  int      due_wr;
  int      due_count;
  sample_t oldest;

  assign mismatch_count = errors;

  task automatic note_mismatch(input string what, input sample_t want, input sample_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected extremum %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Advances the monotonic window by one sample and queues the extremum the
  // block owes for it, if the window is full.
  task automatic take_sample(input sample_t s, input logic restart);
    int win;
    int age;
    int slot;
    win = int'(regs.window_size);
    if (win == 0) win = 1;
    if (win > WINDOW_MAX) win = WINDOW_MAX;
    if (restart) begin
      head = 0;
      depth = 0;
      next_pos = 0;
      seen = 0;
    end
    if (depth > 0) begin
      age = (next_pos + POS_MOD - kept_pos[head]) % POS_MOD;
      if (age >= win) begin
        head = (head + 1) % WINDOW_MAX;
        depth--;
      end
    end
    while (depth > 0) begin
      slot = (head + depth - 1) % WINDOW_MAX;
      if (regs.find_minimum ? (kept_values[slot] >= s) : (kept_values[slot] <= s)) begin
        depth--;
      end else begin
        break;
      end
    end
    if (depth >= WINDOW_MAX) begin
      head = (head + 1) % WINDOW_MAX;
      depth--;
    end
    slot = (head + depth) % WINDOW_MAX;
    kept_values[slot] = s;
    kept_pos[slot] = next_pos;
    depth++;
    next_pos = (next_pos + 1) % POS_MOD;
    if (seen < win) seen++;
    if (seen > win) seen = win;
    if (seen >= win) begin
      if (due_count >= DUE_DEPTH) begin
        note_mismatch("too many results outstanding", kept_values[head], 'x);
      end else begin
        due_values[due_wr] = kept_values[head];
        due_wr = (due_wr + 1) % DUE_DEPTH;
        due_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.window_size = WINDOW_SIZE_W'(1);
      regs.find_minimum = 1'b0;
      head = 0;
      depth = 0;
      next_pos = 0;
      seen = 0;
      due_rd = 0;
      due_wr = 0;
      due_count = 0;
    end else begin
      // A result leaving at this edge belongs to an earlier request, so it is
      // matched before the request taken at the same edge is predicted.
      if (out_valid && !out_stall) begin
        if (due_count == 0) begin
          note_mismatch("result with nothing outstanding", 'x, out_extremum);
        end else begin
          oldest = due_values[due_rd];
          due_rd = (due_rd + 1) % DUE_DEPTH;
          due_count--;
          if (out_extremum !== oldest) note_mismatch("wrong extremum", oldest, out_extremum);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_WINDOW_SIZE:  regs.window_size = cfg_data[WINDOW_SIZE_W-1:0];
          CFG_FIND_MINIMUM: regs.find_minimum = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_sample(in_sample, in_start_of_sequence);
    end
    pending_results <= due_count;
  end

endmodule

// ===== test/tb.sv =====
// Regression bench for sliding_window_extremum: drives samples and register
// writes with random idling on both channels. Depends on swe_pkg, the block
// itself and swe_checker, which predicts and compares every result.
`timescale 1ns / 1ps

module tb;
  import swe_pkg::*;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_BITS  = 16;
  // A request passes through one pop step per tail entry it removes, and the
  // deque never holds more than WINDOW_MAX entries, so this covers one
  // request that is still in flight without producing a result.
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 750;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // How the samples of one random phase are shaped. Falling runs build deep
  // deques in maximum mode and rising runs do the same in minimum mode; the
  // narrow shape produces many equal values, which are removed as dominated.
  typedef enum int {
    SHAPE_NOISE,
    SHAPE_NARROW,
    SHAPE_FALLING,
    SHAPE_RISING,
    SHAPE_EXTREME
  } shape_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  sample_t                in_sample;
  logic                   in_start_of_sequence;
  logic                   out_valid;
  logic                   out_stall;
  sample_t                out_extremum;

  int      mismatch_count;
  int      pending_results;
  bit      input_quiet;
  sample_t ramp;

  always #5 clk = ~clk;

  sliding_window_extremum #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .in_start_of_sequence(in_start_of_sequence),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_extremum        (out_extremum)
  );

  swe_checker #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .in_start_of_sequence(in_start_of_sequence),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_extremum        (out_extremum),
    .mismatch_count      (mismatch_count),
    .pending_results     (pending_results)
  );

  // Idle cycles before the next request. Most gaps are short, a few are long,
  // and whole phases run with no gaps at all so that back-to-back requests
  // hit the sequencer too.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (input_quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t next_sample(input shape_t shape);
    case (shape)
      SHAPE_NOISE:   return sample_t'($urandom);
      SHAPE_NARROW:  return sample_t'(int'($urandom_range(0, 8)) - 4);
      SHAPE_FALLING: begin
        ramp = ramp - sample_t'($urandom_range(0, 3));
        return ramp;
      end
      SHAPE_RISING: begin
        ramp = ramp + sample_t'($urandom_range(0, 3));
        return ramp;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return sample_t'(16'sh8000);
          1:       return sample_t'(16'sh7fff);
          2:       return sample_t'(0);
          default: return sample_t'(-1);
        endcase
      end
    endcase
  endfunction

  // Offers one request and returns at the edge that accepts it. Valid stays
  // high afterwards, so a request that follows without a gap is driven in the
  // very next step without valid dropping in between.
  task automatic send_sample(input sample_t value, input logic restart);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= value;
    in_start_of_sequence <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Registers may only change while the block is idle: every predicted result
  // must have left, and a last request that yields no result may still be in
  // the sequencer, hence the extra drain before the two writes.
  task automatic apply_config(input int window, input logic use_min);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WINDOW_SIZE;
    cfg_data <= CFG_DATA_W'(window);
    @(posedge clk);
    cfg_index <= CFG_FIND_MINIMUM;
    cfg_data <= CFG_DATA_W'(use_min);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Downstream stall: runs of readiness, mostly short, sometimes long enough
  // to let many results through untouched, broken by stalls of random length.
  initial begin : result_backpressure
    int r;
    int run;
    int hold;
    out_stall <= 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 70) run = $urandom_range(1, 6);
      else if (r < 90) run = $urandom_range(8, 30);
      else run = $urandom_range(100, 300);
      repeat (run) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 80) hold = $urandom_range(1, 3);
      else if (r < 95) hold = $urandom_range(4, 12);
      else hold = $urandom_range(20, 60);
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    int     taken;
    int     r;
    int     window;
    int     span;
    int     count;
    logic   use_min;
    logic   restart;
    shape_t shape;

    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_WINDOW_SIZE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_sample <= '0;
    in_start_of_sequence <= 1'b0;
    input_quiet = 1'b0;
    ramp = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings give a window of one in maximum mode, so every request
    // returns its own sample; the sample extremes go through here.
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b0);

    // Window of three tracking the maximum, with equal samples that replace
    // each other and the most negative value repeated.
    apply_config(3, 1'b0);
    send_sample(16'sd5, 1'b1);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);

    // Switching to the minimum without restarting keeps the old deque, and
    // the new comparison applies from the next sample on.
    apply_config(3, 1'b1);
    send_sample(16'sd6, 1'b0);
    send_sample(16'sd6, 1'b0);
    send_sample(-16'sd2, 1'b0);

    // A window of zero behaves as one; the shrink also happens mid-sequence,
    // so stale entries drain one per sample.
    apply_config(0, 1'b1);
    send_sample(16'sd4, 1'b0);
    send_sample(-16'sd4, 1'b0);

    // A window above the deque size is clamped to it.
    apply_config(127, 1'b0);
    send_sample(16'sd100, 1'b1);
    send_sample(16'sd99, 1'b0);
    send_sample(16'sd98, 1'b0);

    // Random phases. Each picks new settings, mostly small windows with some
    // full-size, zero and oversize ones, and usually restarts the sequence;
    // the rest carry the old deque across the change.
    taken = 0;
    while (taken < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 45) window = $urandom_range(1, 8);
      else if (r < 70) window = $urandom_range(9, 63);
      else if (r < 85) window = WINDOW_MAX;
      else if (r < 92) window = 0;
      else window = $urandom_range(WINDOW_MAX + 1, 127);
      use_min = 1'($urandom_range(0, 1));
      apply_config(window, use_min);

      if (window == 0) span = 1;
      else if (window > WINDOW_MAX) span = WINDOW_MAX;
      else span = window;
      count = span + $urandom_range(4, 40);
      shape = shape_t'($urandom_range(0, 4));
      ramp = sample_t'($urandom);
      input_quiet = ($urandom_range(0, 3) == 0);
      restart = ($urandom_range(0, 3) != 0);

      for (int i = 0; i < count; i++) begin
        send_sample(next_sample(shape), restart);
        restart = ($urandom_range(0, 99) < 3);
        taken++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sliding_window_extremum regression: pass");
    end else begin
      $display("sliding_window_extremum regression: fail");
    end
    $finish;
  end

  // The slowest correct run stays far below this, even with every request
  // meeting the longest gaps and stalls.
  initial begin : watchdog
    #10_000_000;
    $display("sliding_window_extremum regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/swe_pkg.sv
rtl/swe_deque_mem.sv
rtl/swe_seq.sv
rtl/sliding_window_extremum.sv
test/swe_checker.sv
test/tb.sv
